// File: src/rl_pkg.sv
// ----------------------------------------------------------------------------
// rl_pkg
// Shared types and constants for the per-source connection rate limiter.
// ----------------------------------------------------------------------------
package rl_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W        = 32;
   localparam int ATT_W         = 16;
   localparam int STATUS_W      = 3;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPT_LIMIT     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PREVENTION_ENABLE = CSR_IDX_W'(1);

   localparam logic CMD_ATTEMPT = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BYPASS  = 3'd5;

   localparam logic [ATT_W-1:0] LIMIT_RESET  = ATT_W'(5);
   localparam logic [ATT_W-1:0] ATT_MAX      = {ATT_W{1'b1}};
   localparam logic [ATT_W-1:0] ATT_ONE      = ATT_W'(1);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ATT_W-1:0]  attempts;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [ATT_W-1:0] attempt_limit;
      logic             prevention_enable;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_req_type;

endpackage

// File: src/rl_ram.sv
// ----------------------------------------------------------------------------
// rl_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rl_csr.sv
// ----------------------------------------------------------------------------
// rl_csr
// Configuration registers: attempt limit and prevention enable.
// ----------------------------------------------------------------------------
module rl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rl_pkg::CSR_DATA_W-1:0]  csr_data,
   output rl_pkg::cfg_type                cfg
);

   rl_pkg::cfg_type cfg_ff;
   rl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rl_pkg::CSR_ATTEMPT_LIMIT: begin
               cfg_in.attempt_limit = csr_data[rl_pkg::ATT_W-1:0];
            end
            rl_pkg::CSR_PREVENTION_ENABLE: begin
               cfg_in.prevention_enable = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attempt_limit     <= rl_pkg::LIMIT_RESET;
         cfg_ff.prevention_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// File: src/rl_engine.sv
// ----------------------------------------------------------------------------
// rl_engine
// Sequencer: scans the occupied prefix of the table one entry a cycle, then
// updates or appends an entry unless over limit or full; posts the result word.
// ----------------------------------------------------------------------------
module rl_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  rl_pkg::cfg_type               cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [rl_pkg::ADDR_W-1:0]     req_source_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_blocked,
   output logic [rl_pkg::STATUS_W-1:0]   rsp_status,
   output rl_pkg::ram_req_type           ram_req,
   input  rl_pkg::entry_type             rd_data
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   localparam logic [rl_pkg::CNT_W-1:0] ENTRIES_CNT = rl_pkg::CNT_W'(rl_pkg::TABLE_ENTRIES);
   localparam logic [rl_pkg::CNT_W-1:0] CNT_ONE     = rl_pkg::CNT_W'(1);

   state_type                     state_ff, state_in;
   logic [rl_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [rl_pkg::CNT_W-1:0]      issue_ff, issue_in;
   logic                          pend_ff, pend_in;
   logic [rl_pkg::IDX_W-1:0]      pidx_ff, pidx_in;
   logic [rl_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                          res_blocked_ff, res_blocked_in;
   logic [rl_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_blocked_ff, rsp_blocked_in;
   logic [rl_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                          hit;

   assign hit = pend_ff && (rd_data.address == addr_ff);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      pidx_in        = pidx_ff;
      count_in       = count_ff;
      res_blocked_in = res_blocked_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_status_in  = rsp_status_ff;
      ram_req        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == rl_pkg::CMD_CLEAR) begin
                  count_in       = '0;
                  res_blocked_in = 1'b0;
                  res_status_in  = rl_pkg::ST_CLEARED;
                  state_in       = S_DONE;
               end else if (!cfg.prevention_enable) begin
                  res_blocked_in = 1'b0;
                  res_status_in  = rl_pkg::ST_BYPASS;
                  state_in       = S_DONE;
               end else begin
                  addr_in  = req_source_address;
                  issue_in = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               pend_in = 1'b0;
               if (rd_data.attempts >= cfg.attempt_limit) begin
                  res_blocked_in = 1'b1;
                  res_status_in  = rl_pkg::ST_OVER;
               end else begin
                  ram_req.wr_en            = 1'b1;
                  ram_req.wr_addr          = pidx_ff;
                  ram_req.wr_data.address  = addr_ff;
                  ram_req.wr_data.attempts = (rd_data.attempts == rl_pkg::ATT_MAX) ?
                                             rd_data.attempts :
                                             rd_data.attempts + rl_pkg::ATT_ONE;
                  res_blocked_in = 1'b0;
                  res_status_in  = rl_pkg::ST_COUNTED;
               end
               state_in = S_DONE;
            end else if (issue_ff < count_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = issue_ff[rl_pkg::IDX_W-1:0];
               pend_in         = 1'b1;
               pidx_in         = issue_ff[rl_pkg::IDX_W-1:0];
               issue_in        = issue_ff + CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (count_ff == ENTRIES_CNT) begin
                  res_blocked_in = 1'b1;
                  res_status_in  = rl_pkg::ST_FULL;
               end else begin
                  ram_req.wr_en            = 1'b1;
                  ram_req.wr_addr          = count_ff[rl_pkg::IDX_W-1:0];
                  ram_req.wr_data.address  = addr_ff;
                  ram_req.wr_data.attempts = rl_pkg::ATT_ONE;
                  count_in                 = count_ff + CNT_ONE;
                  res_blocked_in           = 1'b0;
                  res_status_in            = rl_pkg::ST_NEW;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_blocked_in = res_blocked_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      pidx_ff        <= pidx_in;
      res_blocked_ff <= res_blocked_in;
      res_status_ff  <= res_status_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blocked = rsp_blocked_ff;
   assign rsp_status  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_CNT)
      else $error("occupancy above table size");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> issue_ff <= count_ff)
      else $error("scan index past occupied entries");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (state_ff == S_SCAN) && !ram_req.rd_en)
      else $error("table write outside scan");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == rl_pkg::CMD_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && state_in == S_DONE && res_status_in == rl_pkg::ST_NEW)
      |=> count_ff == $past(count_ff) + CNT_ONE)
      else $error("new entry without occupancy step");

endmodule

// File: src/per_source_connection_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_connection_rate_limiter
// Top level: configuration registers, scan sequencer and entry table.
// ----------------------------------------------------------------------------
// Each connection attempt is looked up in a table of up to TABLE_ENTRIES
// source addresses held in one RAM (address and attempt count per entry).
// Entries fill from slot zero upwards and are only dropped all at once by a
// clear, so an occupancy count marks the live entries and no clearing pass
// is needed after reset. An attempt reads one entry a cycle through the RAM
// port, so the time it takes grows with the occupancy and is shorter when
// the address is found early; a clear or a bypassed attempt reads no entry.
// One word is worked on at a time; the next is taken while the previous
// result word waits in the output register.
// ----------------------------------------------------------------------------
module per_source_connection_rate_limiter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [rl_pkg::ADDR_W-1:0]     req_source_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_blocked,
   output logic [rl_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rl_pkg::CSR_DATA_W-1:0] csr_data
);

   rl_pkg::cfg_type     cfg;
   rl_pkg::ram_req_type ram_req;
   rl_pkg::entry_type   rd_data;
   logic [rl_pkg::ENTRY_W-1:0] rd_word;

   rl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rl_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_source_address (req_source_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blocked        (rsp_blocked),
      .rsp_status         (rsp_status),
      .ram_req            (ram_req),
      .rd_data            (rd_data)
   );

   rl_ram #(
      .WIDTH  (rl_pkg::ENTRY_W),
      .DEPTH  (rl_pkg::TABLE_ENTRIES),
      .ADDR_W (rl_pkg::IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_word),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data)
   );

   assign rd_data = rd_word;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-source connection rate limiter.
// ----------------------------------------------------------------------------
// A directed table covers reset settings, the count limit, clear, bypass, a
// zero limit, the largest limit and ignored register writes. Random episodes
// follow. Most draw attempts from small address pools, so counting and
// blocking are reached. Some flood the table until it is full. Every result
// word is checked against the row's expectation or a shadow copy of the table.
// Sender gaps and receiver stalls are random, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import rl_pkg::*;

   localparam int RANDOM_WORDS    = 1800;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TAIL_CYCLES     = TABLE_ENTRIES + 40;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int MAX_REPORTS     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = CSR_PREVENTION_ENABLE + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNMAPPED  = {CSR_IDX_W{1'b1}};

   localparam logic [ADDR_W-1:0] ADDR_A   = 32'hC0A8_0A01;
   localparam logic [ADDR_W-1:0] ADDR_B   = 32'h0A00_0002;
   localparam logic [ADDR_W-1:0] ADDR_LOW = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] ADDR_TOP = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                blocked;
      logic [STATUS_W-1:0] status;
   } verdict_t;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t             kind;
      logic                  command;
      logic [ADDR_W-1:0]     address;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_value;
      logic                  typed;
      logic                  exp_blocked;
      logic [STATUS_W-1:0]   exp_status;
   } stim_row_t;

   // unused fields of a row hold placeholders
   stim_row_t directed_plan [25] = '{
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_COUNTED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_COUNTED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_COUNTED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_COUNTED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b1, ST_OVER},
      '{ROW_WORD, CMD_CLEAR,   ADDR_TOP, '0, '0, 1'b1, 1'b0, ST_CLEARED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_LOW, '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_TOP, '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_LOW, '0, '0, 1'b0, 1'b0, ST_NEW},
      '{ROW_CSR,  CMD_ATTEMPT, '0, CSR_PREVENTION_ENABLE, 16'h0000, 1'b0, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_TOP, '0, '0, 1'b1, 1'b0, ST_BYPASS},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_B,   '0, '0, 1'b1, 1'b0, ST_BYPASS},
      '{ROW_WORD, CMD_CLEAR,   ADDR_LOW, '0, '0, 1'b1, 1'b0, ST_CLEARED},
      '{ROW_CSR,  CMD_ATTEMPT, '0, CSR_PREVENTION_ENABLE, 16'hFFFF, 1'b0, 1'b0, ST_NEW},
      '{ROW_CSR,  CMD_ATTEMPT, '0, CSR_ATTEMPT_LIMIT,     16'h0000, 1'b0, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_B,   '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_B,   '0, '0, 1'b1, 1'b1, ST_OVER},
      '{ROW_CSR,  CMD_ATTEMPT, '0, CSR_LAST_UNMAPPED,     16'h0001, 1'b0, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_B,   '0, '0, 1'b1, 1'b1, ST_OVER},
      '{ROW_CSR,  CMD_ATTEMPT, '0, CSR_ATTEMPT_LIMIT,     16'hFFFF, 1'b0, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_B,   '0, '0, 1'b1, 1'b0, ST_COUNTED},
      '{ROW_WORD, CMD_ATTEMPT, ADDR_A,   '0, '0, 1'b1, 1'b0, ST_NEW},
      '{ROW_WORD, CMD_CLEAR,   ADDR_B,   '0, '0, 1'b1, 1'b0, ST_CLEARED}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = CMD_ATTEMPT;
   logic [ADDR_W-1:0]     req_source_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_blocked;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow copy of the block's table and registers
   logic [ADDR_W-1:0]        shadow_address [TABLE_ENTRIES];
   logic [ATT_W-1:0]         shadow_attempts [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] shadow_live = '0;
   int                       shadow_fill = 0;
   logic [ATT_W-1:0]         cfg_limit = LIMIT_RESET;
   logic                     cfg_enable = 1'b1;

   verdict_t pending_verdicts [$];

   int       err_count = 0;
   int       status_seen [6] = '{default: 0};
   int       burst_left = 0;
   int       word_total = 0;
   int       directed_words = 0;
   int       csr_writes = 0;
   int       episode = 0;
   int       pool_size;
   int       word_run;
   int       pick;
   int       spin;
   logic     hold_off_req = 1'b0;
   int       rx_mode = 0;
   int       rx_left = 0;
   logic [CSR_DATA_W-1:0] limit_pick;
   logic [CSR_DATA_W-1:0] enable_pick;
   logic                  flood;
   logic [ADDR_W-1:0]     fresh;
   logic [ADDR_W-1:0]     pool [64];
   logic [ADDR_W-1:0]     flood_seen [$];

   per_source_connection_rate_limiter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_source_address (req_source_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blocked        (rsp_blocked),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   function automatic verdict_t rate_verdict(input logic cmd, input logic [ADDR_W-1:0] addr);
      verdict_t v;
      int       free_slot;
      free_slot = -1;
      v.blocked = 1'b0;
      if (cmd == CMD_CLEAR) begin
         shadow_live = '0;
         shadow_fill = 0;
         v.status = ST_CLEARED;
         return v;
      end
      if (!cfg_enable) begin
         v.status = ST_BYPASS;
         return v;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (shadow_live[i]) begin
            if (shadow_address[i] == addr) begin
               if (shadow_attempts[i] >= cfg_limit) begin
                  v.blocked = 1'b1;
                  v.status = ST_OVER;
                  return v;
               end
               if (shadow_attempts[i] != ATT_MAX)
                  shadow_attempts[i] = shadow_attempts[i] + ATT_ONE;
               v.status = ST_COUNTED;
               return v;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (shadow_fill >= TABLE_ENTRIES || free_slot < 0) begin
         v.blocked = 1'b1;
         v.status = ST_FULL;
         return v;
      end
      shadow_live[free_slot] = 1'b1;
      shadow_address[free_slot] = addr;
      shadow_attempts[free_slot] = ATT_ONE;
      shadow_fill++;
      v.status = ST_NEW;
      return v;
   endfunction

   // offer one word; a burst keeps valid high, otherwise a random gap first
   task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                            input logic typed, input verdict_t typed_verdict);
      int       gap;
      verdict_t v;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_source_address = addr;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      v = rate_verdict(cmd, addr);
      pending_verdicts.push_back(typed ? typed_verdict : v);
      word_total++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ATTEMPT_LIMIT:     cfg_limit = value;
         CSR_PREVENTION_ENABLE: cfg_enable = value[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      verdict_t exp_v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_status < 6)
            status_seen[rsp_status]++;
         if (pending_verdicts.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("unexpected result word: blocked=%0d status=%0d", rsp_blocked, rsp_status);
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_blocked !== exp_v.blocked || rsp_status !== exp_v.status) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("mismatch: blocked exp %0d got %0d, status exp %0d got %0d",
                           exp_v.blocked, rsp_blocked, exp_v.status, rsp_status);
            end
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 96);
         end
         rx_left--;
         case (rx_mode)
            0:       rsp_ready = 1'b1;
            1:       rsp_ready = ($urandom_range(0, 3) != 0);
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
         @(negedge clock);
      end
   end

   initial begin
      #60_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR)
            write_reg(directed_plan[i].csr_idx, directed_plan[i].csr_value);
         else
            send_word(directed_plan[i].command, directed_plan[i].address, directed_plan[i].typed,
                      '{blocked: directed_plan[i].exp_blocked, status: directed_plan[i].exp_status});
      end
      directed_words = word_total;
      word_total = 0;

      while (word_total < RANDOM_WORDS) begin
         flood = (episode == 3 || episode == 14);
         case ($urandom_range(0, 9))
            0:       limit_pick = '0;
            1:       limit_pick = 16'd1;
            2:       limit_pick = '1;
            3:       limit_pick = CSR_DATA_W'($urandom);
            default: limit_pick = CSR_DATA_W'($urandom_range(2, 8));
         endcase
         enable_pick = CSR_DATA_W'($urandom);
         enable_pick[0] = flood || ($urandom_range(0, 7) != 0);
         write_reg(CSR_ATTEMPT_LIMIT, limit_pick);
         write_reg(CSR_PREVENTION_ENABLE, enable_pick);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)),
                      CSR_DATA_W'($urandom));
         if (episode == 1) begin
            hold_off_req = 1'b1;
            burst_left = 60;
         end

         if (flood) begin
            // fill every slot, then probe a full table with new and known sources
            flood_seen.delete();
            send_word(CMD_CLEAR, ADDR_W'($urandom), 1'b0, '0);
            for (int k = 0; k < TABLE_ENTRIES + 12; k++) begin
               if (flood_seen.size() != 0 && $urandom_range(0, 3) == 0)
                  send_word(CMD_ATTEMPT, flood_seen[$urandom_range(0, flood_seen.size() - 1)],
                            1'b0, '0);
               fresh = ADDR_W'($urandom);
               flood_seen.push_back(fresh);
               send_word(CMD_ATTEMPT, fresh, 1'b0, '0);
            end
         end else begin
            pool_size = $urandom_range(2, 40);
            for (int j = 0; j < pool_size; j++) begin
               case ($urandom_range(0, 9))
                  0:       pool[j] = ADDR_LOW;
                  1:       pool[j] = ADDR_TOP;
                  2, 3:    pool[j] = (j == 0) ? ADDR_A : pool[j-1] ^ (32'h1 << $urandom_range(0, 31));
                  default: pool[j] = ADDR_W'($urandom);
               endcase
            end
            if ($urandom_range(0, 1) == 0)
               send_word(CMD_CLEAR, ADDR_W'($urandom), 1'b0, '0);
            word_run = $urandom_range(30, 90);
            for (int k = 0; k < word_run; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 3)
                  send_word(CMD_CLEAR, ADDR_W'($urandom), 1'b0, '0);
               else if (pick < 6)
                  send_word(CMD_ATTEMPT, ADDR_W'($urandom), 1'b0, '0);
               else
                  send_word(CMD_ATTEMPT, pool[$urandom_range(0, pool_size - 1)], 1'b0, '0);
               if ($urandom_range(0, 49) == 0)
                  wait_drain();
            end
         end
         episode++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      spin = 0;
      while (pending_verdicts.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         err_count += pending_verdicts.size();
         $display("%0d result words never arrived", pending_verdicts.size());
      end

      $display("covered %0d directed and %0d random words in %0d episodes, %0d register writes",
               directed_words, word_total, episode, csr_writes);
      $display("outcomes: new %0d, counted %0d, over limit %0d, full %0d, cleared %0d, bypass %0d",
               status_seen[ST_NEW], status_seen[ST_COUNTED], status_seen[ST_OVER],
               status_seen[ST_FULL], status_seen[ST_CLEARED], status_seen[ST_BYPASS]);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: per_source_connection_rate_limiter.f
src/rl_pkg.sv
src/rl_ram.sv
src/rl_csr.sv
src/rl_engine.sv
src/per_source_connection_rate_limiter.sv
tb/sv/testbench.sv
